>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the connection state machine top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> src/doipcsm_pkg.sv
// ----------------------------------------------------------------------------
// doipcsm_pkg
// Types, codes and reset values for the DoIP connection state machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package doipcsm_pkg;

   // Event kinds on the request channel
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_MESSAGE = 2'd1;
   localparam logic [1:0] REQ_CLOSE   = 2'd2;
   localparam logic [1:0] REQ_ERROR   = 2'd3;

   // Payload classes of a received message
   localparam logic [1:0] CLS_ROUTING_REQ = 2'd0;
   localparam logic [1:0] CLS_ALIVE_RSP   = 2'd1;
   localparam logic [1:0] CLS_DIAG        = 2'd2;
   localparam logic [1:0] CLS_OTHER       = 2'd3;

   // Send command codes
   localparam logic [2:0] SEND_NONE      = 3'd0;
   localparam logic [2:0] SEND_ROUTE_RSP = 3'd1;
   localparam logic [2:0] SEND_ALIVE_REQ = 3'd2;
   localparam logic [2:0] SEND_DIAG_ACK  = 3'd3;
   localparam logic [2:0] SEND_DIAG_NACK = 3'd4;

   // Close reasons
   localparam logic [2:0] CLOSE_INIT_TIMEOUT  = 3'd0;
   localparam logic [2:0] CLOSE_ALIVE_TIMEOUT = 3'd1;
   localparam logic [2:0] CLOSE_APP_REQUEST   = 3'd2;
   localparam logic [2:0] CLOSE_INVALID_MSG   = 3'd3;
   localparam logic [2:0] CLOSE_SOCKET_ERROR  = 3'd4;

   // Reported state codes
   localparam logic [2:0] CODE_INIT         = 3'd0;
   localparam logic [2:0] CODE_WAIT_ROUTING = 3'd1;
   localparam logic [2:0] CODE_ROUTED       = 3'd2;
   localparam logic [2:0] CODE_WAIT_ALIVE   = 3'd3;
   localparam logic [2:0] CODE_CLOSED       = 3'd4;

   // Register indexes
   localparam logic [1:0] CSR_INITIAL_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_GENERAL_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_ALIVE_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_SERVER_ADDRESS  = 2'd3;

   // Register reset values
   localparam logic [31:0] RST_INITIAL_TIMEOUT = 32'd2000;
   localparam logic [31:0] RST_GENERAL_TIMEOUT = 32'd300000;
   localparam logic [31:0] RST_ALIVE_TIMEOUT   = 32'd500;
   localparam logic [15:0] RST_SERVER_ADDRESS  = 16'd0;

   // Connection state, one-hot
   typedef enum logic [4:0] {
      ST_INIT         = 5'b00001,
      ST_WAIT_ROUTING = 5'b00010,
      ST_ROUTED       = 5'b00100,
      ST_WAIT_ALIVE   = 5'b01000,
      ST_CLOSED       = 5'b10000
   } conn_state_type;

   // Running timer
   typedef enum logic [1:0] {
      TM_NONE    = 2'd0,
      TM_INITIAL = 2'd1,
      TM_GENERAL = 2'd2,
      TM_ALIVE   = 2'd3
   } timer_kind_type;

   // One request beat
   typedef struct packed {
      logic [1:0]  req_type;
      logic [1:0]  payload_class;
      logic        has_source;
      logic [15:0] src_address;
      logic        app_nack_valid;
      logic [7:0]  app_nack_code;
   } req_item_type;

   // One response beat
   typedef struct packed {
      logic [2:0]  send_kind;
      logic [15:0] dest_address;
      logic [15:0] peer_address;
      logic [7:0]  nack_code_out;
      logic        close_now;
      logic [2:0]  close_reason;
      logic [2:0]  state_now;
   } rsp_item_type;

   // Configuration register set
   typedef struct packed {
      logic [31:0] initial_timeout;
      logic [31:0] general_timeout;
      logic [31:0] alive_timeout;
      logic [15:0] server_address;
   } cfg_type;

   // Map the one-hot state to its reported code
   function automatic logic [2:0] state_code(input conn_state_type st);
      logic [2:0] code;
      unique case (st)
         ST_INIT:         code = CODE_INIT;
         ST_WAIT_ROUTING: code = CODE_WAIT_ROUTING;
         ST_ROUTED:       code = CODE_ROUTED;
         ST_WAIT_ALIVE:   code = CODE_WAIT_ALIVE;
         default:         code = CODE_CLOSED;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> src/doipcsm_core.sv
// ----------------------------------------------------------------------------
// doipcsm_core
// Connection state, client address and timer; computes one response per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module doipcsm_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        step,
   input  doipcsm_pkg::req_item_type  item,
   input  doipcsm_pkg::cfg_type       cfg,
   output doipcsm_pkg::rsp_item_type  result
);

   doipcsm_pkg::conn_state_type state_ff, state_in;
   doipcsm_pkg::timer_kind_type tkind_ff, tkind_in;
   logic [15:0]                 client_ff, client_in;
   logic [31:0]                 tcount_ff, tcount_in;

   // Next state and response for the beat in the input register
   always_comb begin
      logic       do_close;
      logic [2:0] reason;
      state_in  = state_ff;
      tkind_in  = tkind_ff;
      client_in = client_ff;
      tcount_in = tcount_ff;
      result    = '0;
      do_close  = 1'b0;
      reason    = doipcsm_pkg::CLOSE_INIT_TIMEOUT;

      unique case (state_ff)
         doipcsm_pkg::ST_CLOSED: begin
            // every beat ignored
         end
         doipcsm_pkg::ST_INIT,
         doipcsm_pkg::ST_WAIT_ROUTING,
         doipcsm_pkg::ST_ROUTED,
         doipcsm_pkg::ST_WAIT_ALIVE: begin
            priority if (item.req_type == doipcsm_pkg::REQ_TICK) begin
               if (tkind_ff != doipcsm_pkg::TM_NONE) begin
                  if (tcount_ff > 32'd1) begin
                     tcount_in = tcount_ff - 32'd1;
                  end else begin
                     tkind_in  = doipcsm_pkg::TM_NONE;
                     tcount_in = '0;
                     unique case (tkind_ff)
                        doipcsm_pkg::TM_INITIAL: begin
                           do_close = 1'b1;
                           reason   = doipcsm_pkg::CLOSE_INIT_TIMEOUT;
                        end
                        doipcsm_pkg::TM_ALIVE: begin
                           do_close = 1'b1;
                           reason   = doipcsm_pkg::CLOSE_ALIVE_TIMEOUT;
                        end
                        default: begin
                           // general inactivity: probe the client
                           result.send_kind = doipcsm_pkg::SEND_ALIVE_REQ;
                           tkind_in         = doipcsm_pkg::TM_ALIVE;
                           tcount_in        = cfg.alive_timeout;
                           state_in         = doipcsm_pkg::ST_WAIT_ALIVE;
                        end
                     endcase
                  end
               end
            end else if (item.req_type == doipcsm_pkg::REQ_CLOSE) begin
               do_close = 1'b1;
               reason   = doipcsm_pkg::CLOSE_APP_REQUEST;
            end else if (item.req_type == doipcsm_pkg::REQ_ERROR) begin
               do_close = 1'b1;
               reason   = doipcsm_pkg::CLOSE_SOCKET_ERROR;
            end else if (item.payload_class == doipcsm_pkg::CLS_OTHER) begin
               do_close = 1'b1;
               reason   = doipcsm_pkg::CLOSE_INVALID_MSG;
            end else begin
               // received message, handled per state
               unique case (state_ff)
                  doipcsm_pkg::ST_INIT: begin
                     state_in  = doipcsm_pkg::ST_WAIT_ROUTING;
                     tkind_in  = doipcsm_pkg::TM_INITIAL;
                     tcount_in = cfg.initial_timeout;
                  end
                  doipcsm_pkg::ST_WAIT_ROUTING: begin
                     if (item.payload_class == doipcsm_pkg::CLS_ROUTING_REQ) begin
                        if (!item.has_source) begin
                           do_close = 1'b1;
                           reason   = doipcsm_pkg::CLOSE_INVALID_MSG;
                        end else begin
                           client_in           = item.src_address;
                           result.send_kind    = doipcsm_pkg::SEND_ROUTE_RSP;
                           result.dest_address = item.src_address;
                           result.peer_address = cfg.server_address;
                           tkind_in            = doipcsm_pkg::TM_GENERAL;
                           tcount_in           = cfg.general_timeout;
                           state_in            = doipcsm_pkg::ST_ROUTED;
                        end
                     end
                  end
                  doipcsm_pkg::ST_ROUTED: begin
                     if (item.payload_class == doipcsm_pkg::CLS_DIAG && item.has_source) begin
                        result.send_kind    = item.app_nack_valid ?
                                              doipcsm_pkg::SEND_DIAG_NACK :
                                              doipcsm_pkg::SEND_DIAG_ACK;
                        result.dest_address = item.src_address;
                        result.peer_address = client_ff;
                        result.nack_code_out = item.app_nack_valid ? item.app_nack_code : 8'd0;
                        tkind_in            = doipcsm_pkg::TM_GENERAL;
                        tcount_in           = cfg.general_timeout;
                     end
                  end
                  default: begin
                     // waiting for the alive check response
                     if (item.payload_class == doipcsm_pkg::CLS_ALIVE_RSP) begin
                        tkind_in  = doipcsm_pkg::TM_GENERAL;
                        tcount_in = cfg.general_timeout;
                        state_in  = doipcsm_pkg::ST_ROUTED;
                     end else if (item.payload_class == doipcsm_pkg::CLS_DIAG) begin
                        tkind_in  = doipcsm_pkg::TM_NONE;
                        tcount_in = '0;
                        if (item.has_source) begin
                           result.send_kind    = doipcsm_pkg::SEND_DIAG_ACK;
                           result.dest_address = item.src_address;
                           result.peer_address = client_ff;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            // illegal encoding falls back to closed
            state_in = doipcsm_pkg::ST_CLOSED;
         end
      endcase

      // closing stops the timer; client address is kept
      if (do_close) begin
         state_in            = doipcsm_pkg::ST_CLOSED;
         tkind_in            = doipcsm_pkg::TM_NONE;
         tcount_in           = '0;
         result.close_now    = 1'b1;
         result.close_reason = reason;
      end

      result.state_now = doipcsm_pkg::state_code(state_in);
   end

   // State update, once per beat leaving the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= doipcsm_pkg::ST_INIT;
         tkind_ff  <= doipcsm_pkg::TM_NONE;
         client_ff <= '0;
         tcount_ff <= '0;
      end else if (step) begin
         state_ff  <= state_in;
         tkind_ff  <= tkind_in;
         client_ff <= client_in;
         tcount_ff <= tcount_in;
      end
   end

endmodule

`default_nettype wire

>>> src/doip_connection_state_machine_top.sv
// A request beat accepted into the input register is loaded into the result
// register when it advances, and its response beat is taken from there.
// Throughput: one beat per cycle, set by the state update between the two
// registers; a response stall holds both stages.
// Reset (synchronous, active high): state socket initialized, no timer,
// client address 0, registers to 2000 / 300000 / 500 / 0, both stages empty.
// ----------------------------------------------------------------------------
// doip_connection_state_machine_top
// Per-connection DoIP server state machine with valid/stall channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module doip_connection_state_machine_top (
   input  wire         clock,
   input  wire         reset,
   // configuration
   input  wire         csr_wr_en,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_wdata,
   // request channel
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_type,
   input  wire  [1:0]  req_payload_class,
   input  wire         req_has_source,
   input  wire  [15:0] req_src_address,
   input  wire         req_app_nack_valid,
   input  wire  [7:0]  req_app_nack_code,
   // response channel
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_send_kind,
   output logic [15:0] rsp_dest_address,
   output logic [15:0] rsp_peer_address,
   output logic [7:0]  rsp_nack_code_out,
   output logic        rsp_close_now,
   output logic [2:0]  rsp_close_reason,
   output logic [2:0]  rsp_state_now
);

   doipcsm_pkg::cfg_type      cfg_ff;
   doipcsm_pkg::req_item_type in_item_ff;
   doipcsm_pkg::rsp_item_type out_item_ff;
   doipcsm_pkg::rsp_item_type core_result;
   logic                      in_valid_ff, in_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_ready, in_ready, advance, accept;
   logic                      rsp_closing, rsp_sends, rsp_alive_req;
   logic                      rsp_in_alive, rsp_is_closed, rsp_taken;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_timeout <= doipcsm_pkg::RST_INITIAL_TIMEOUT;
         cfg_ff.general_timeout <= doipcsm_pkg::RST_GENERAL_TIMEOUT;
         cfg_ff.alive_timeout   <= doipcsm_pkg::RST_ALIVE_TIMEOUT;
         cfg_ff.server_address  <= doipcsm_pkg::RST_SERVER_ADDRESS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            doipcsm_pkg::CSR_INITIAL_TIMEOUT: cfg_ff.initial_timeout <= csr_wdata;
            doipcsm_pkg::CSR_GENERAL_TIMEOUT: cfg_ff.general_timeout <= csr_wdata;
            doipcsm_pkg::CSR_ALIVE_TIMEOUT:   cfg_ff.alive_timeout   <= csr_wdata;
            doipcsm_pkg::CSR_SERVER_ADDRESS:  cfg_ff.server_address  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Handshake: result register frees when empty or taken this cycle
   assign out_ready    = !out_valid_ff || !rsp_stall;
   assign in_ready     = !in_valid_ff || out_ready;
   assign advance      = in_valid_ff && out_ready;
   assign req_stall    = !in_ready;
   assign accept       = req_valid && in_ready;
   assign in_valid_in  = in_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.req_type       <= req_type;
         in_item_ff.payload_class  <= req_payload_class;
         in_item_ff.has_source     <= req_has_source;
         in_item_ff.src_address    <= req_src_address;
         in_item_ff.app_nack_valid <= req_app_nack_valid;
         in_item_ff.app_nack_code  <= req_app_nack_code;
      end
   end

   doipcsm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_send_kind     = out_item_ff.send_kind;
   assign rsp_dest_address  = out_item_ff.dest_address;
   assign rsp_peer_address  = out_item_ff.peer_address;
   assign rsp_nack_code_out = out_item_ff.nack_code_out;
   assign rsp_close_now     = out_item_ff.close_now;
   assign rsp_close_reason  = out_item_ff.close_reason;
   assign rsp_state_now     = out_item_ff.state_now;

   // Checks
   assign rsp_closing   = rsp_valid && rsp_close_now;
   assign rsp_sends     = (rsp_send_kind != doipcsm_pkg::SEND_NONE);
   assign rsp_alive_req = rsp_valid && (rsp_send_kind == doipcsm_pkg::SEND_ALIVE_REQ);
   assign rsp_in_alive  = (rsp_state_now == doipcsm_pkg::CODE_WAIT_ALIVE);
   assign rsp_is_closed = (rsp_state_now == doipcsm_pkg::CODE_CLOSED);
   assign rsp_taken     = rsp_valid && !rsp_stall;

   `ASSERT_IMPLIES(a_close_reports_closed, clock, reset, rsp_closing, rsp_is_closed)
   `ASSERT_IMPLIES(a_no_send_on_close, clock, reset, rsp_closing, !rsp_sends)
   `ASSERT_IMPLIES(a_alive_req_state, clock, reset, rsp_alive_req, rsp_in_alive)
   `ASSERT_NEXT(a_closed_sticky, clock, reset, rsp_taken && rsp_is_closed, !rsp_valid || rsp_is_closed)

endmodule

`default_nettype wire
